[hw/rtl/trre_pkg.sv]
`default_nettype none

package trre_pkg;

	// Table and I/O sizing
	localparam int MAX_RULES     = 16;
	localparam int DIGITAL_COUNT = 8;
	localparam int ANALOG_COUNT  = 4;
	localparam int RELAY_COUNT   = 4;

	// Rule count needs to hold MAX_RULES itself
	localparam int TOTAL_W = $clog2(MAX_RULES + 1);

	// Fixed field widths
	localparam int DI_W     = 8;
	localparam int AI_W     = 16;
	localparam int AI_NUM   = 4;
	localparam int RELAY_W  = 4;
	localparam int SLOT_W   = 4;
	localparam int THRESH_W = 16;

	// Item kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_EVAL  = 2'd2;

	// Rule source codes
	localparam logic [1:0] SRC_DIGITAL = 2'd0;
	localparam logic [1:0] SRC_ANALOG  = 2'd1;

	// Rule condition codes
	localparam logic [1:0] COND_EQUAL = 2'd0;
	localparam logic [1:0] COND_ABOVE = 2'd1;
	localparam logic [1:0] COND_BELOW = 2'd2;

	// Stored rule, 26 bits
	typedef struct packed {
		logic                enable;
		logic                analog;
		logic [1:0]          cond;
		logic [2:0]          chan;
		logic [1:0]          relay;
		logic                action;
		logic [THRESH_W-1:0] threshold;
	} rule_t;

	// Scan token walking down the cell row
	typedef struct packed {
		logic               valid;
		logic [RELAY_W-1:0] cmds;
		logic [RELAY_W-1:0] applied;
	} tok_t;

	typedef logic [AI_NUM-1:0][AI_W-1:0] ai_vec_t;

	// One result item
	typedef struct packed {
		logic               status;
		logic [SLOT_W-1:0]  slot;
		logic [RELAY_W-1:0] cmds;
		logic [RELAY_W-1:0] applied;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/threshold_rule_relay_engine_core.sv]
`default_nettype none

// Threshold rule relay engine.
// Input stream s_axis carries one item per beat: tuser is the item kind
// (clear, add rule, evaluate), tdata the rule word, digital levels and the
// four analog samples. Output stream m_axis returns one result beat per item.
// Rules live in a row of MAX_RULES cells, one rule per cell. An evaluate
// sends a scan token down the row, one cell per cycle; each cell applies its
// rule to the token, so the relay masks come out at the end of the row.
// One item is in work at a time: a clear or add result goes to the pending
// register, and an evaluate keeps s_axis_tready low until its token has
// left the cell row.
// A finished result waits in the output register; one more item may be
// taken and completed behind it, after which s_axis_tready stays low until
// m_axis_tready frees the output.
// Reset empties the rule table (count to zero) and drops any beat in flight.

module threshold_rule_relay_engine_core
	import trre_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// rule_word[31:0], di_bits[39:32], ai_0[55:40], ai_1[71:56],
	// ai_2[87:72], ai_3[103:88]
	input  wire logic [103:0] s_axis_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[0], rule_slot[4:1], relay_commands[8:5], relay_applied[12:9], zeros
	output logic [15:0]       m_axis_tdata
);

	logic [TOTAL_W-1:0] rule_total_q;
	logic               eval_busy_q;
	logic               start_q;
	logic [DI_W-1:0]    di_q;
	ai_vec_t            ai_q;
	logic               pend_valid_q;
	res_t               pend_q;
	logic               out_valid_q;
	res_t               out_q;

	logic               accept;
	logic [31:0]        word;
	logic [1:0]         src;
	rule_t              new_rule;
	logic               chan_ok;
	logic               add_ok;
	logic               out_free;

	tok_t               chain [0:MAX_RULES];
	logic [MAX_RULES-1:0] tok_valid;

	// Handshake
	assign s_axis_tready = !eval_busy_q && !pend_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Rule word decode and validation
	always_comb begin
		word               = s_axis_tdata[31:0];
		src                = word[2:1];
		new_rule.enable    = word[0];
		new_rule.analog    = (src == SRC_ANALOG);
		new_rule.cond      = word[4:3];
		new_rule.chan      = word[7:5];
		new_rule.relay     = word[9:8];
		new_rule.action    = word[10];
		new_rule.threshold = word[31:16];
		case (src)
			SRC_DIGITAL: chan_ok = {1'b0, word[7:5]} < 4'(DIGITAL_COUNT);
			SRC_ANALOG:  chan_ok = {1'b0, word[7:5]} < 4'(ANALOG_COUNT);
			default:     chan_ok = 1'b0;
		endcase
		add_ok = chan_ok && ({1'b0, word[9:8]} < 3'(RELAY_COUNT)) &&
			(rule_total_q < TOTAL_W'(MAX_RULES));
	end

	// Control: table count, scan start, pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_total_q <= '0;
			eval_busy_q  <= 1'b0;
			start_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (accept) begin
				case (s_axis_tuser)
					KIND_CLEAR: begin
						rule_total_q <= '0;
						pend_valid_q <= 1'b1;
					end
					KIND_ADD: begin
						if (add_ok) begin
							rule_total_q <= rule_total_q + TOTAL_W'(1);
						end
						pend_valid_q <= 1'b1;
					end
					KIND_EVAL: begin
						eval_busy_q <= 1'b1;
						start_q     <= 1'b1;
					end
					default: begin
						pend_valid_q <= 1'b1;
					end
				endcase
			end else if (chain[MAX_RULES].valid) begin
				eval_busy_q  <= 1'b0;
				pend_valid_q <= 1'b1;
			end else if (out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Result payload and scan inputs
	always_ff @(posedge clk) begin
		if (accept) begin
			di_q           <= s_axis_tdata[39:32];
			ai_q           <= s_axis_tdata[103:40];
			pend_q.status  <= (s_axis_tuser == KIND_ADD) && !add_ok;
			pend_q.slot    <= ((s_axis_tuser == KIND_ADD) && add_ok) ?
				SLOT_W'(rule_total_q) : '0;
			pend_q.cmds    <= '0;
			pend_q.applied <= '0;
		end else if (chain[MAX_RULES].valid) begin
			pend_q.status  <= 1'b0;
			pend_q.slot    <= '0;
			pend_q.cmds    <= chain[MAX_RULES].cmds;
			pend_q.applied <= chain[MAX_RULES].applied;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pend_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.applied, out_q.cmds, out_q.slot, out_q.status};

	// Row of rule cells
	assign chain[0] = '{valid: start_q, cmds: '0, applied: '0};

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		logic wr_en;
		logic active;

		assign wr_en  = accept && (s_axis_tuser == KIND_ADD) && add_ok &&
			(rule_total_q == TOTAL_W'(i));
		assign active = TOTAL_W'(i) < rule_total_q;
		assign tok_valid[i] = chain[i+1].valid;

		trre_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_rule (new_rule),
			.active  (active),
			.di      (di_q),
			.ai      (ai_q),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

`ifndef SYNTHESIS
	// At most one scan token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_valid, start_q}))
		else $error("more than one scan token in the cell row");

	// A token only travels while an evaluate is open
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		($countones({tok_valid, start_q}) != 0) |-> eval_busy_q)
		else $error("scan token without an open evaluate");

	// Rule count never exceeds the table
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		rule_total_q <= TOTAL_W'(MAX_RULES))
		else $error("rule count past table size");

	// A pending result and an open scan never coexist
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_valid_q && eval_busy_q))
		else $error("pending result while scan open");
`endif

endmodule

`default_nettype wire

[hw/rtl/trre_cell.sv]
`default_nettype none

module trre_cell
	import trre_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire rule_t             wr_rule,
	input  wire logic              active,
	input  wire logic [DI_W-1:0]   di,
	input  wire ai_vec_t           ai,
	input  wire tok_t              tok_in,
	output tok_t                   tok_out
);

	rule_t              rule_q;
	tok_t               tok_q;
	logic               level;
	logic [AI_W-1:0]    sample;
	logic               match;
	logic [RELAY_W-1:0] bit_sel;
	tok_t               tok_nxt;

	// Rule storage, written once per add
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_q <= wr_rule;
		end
	end

	// Condition check against the broadcast scan inputs
	always_comb begin
		level  = di[rule_q.chan];
		sample = ai[rule_q.chan[1:0]];
		match  = 1'b0;
		if (!rule_q.analog) begin
			match = (rule_q.cond == COND_EQUAL) &&
				(rule_q.threshold == {{(THRESH_W-1){1'b0}}, level});
		end else begin
			case (rule_q.cond)
				COND_ABOVE: match = sample > rule_q.threshold;
				COND_BELOW: match = sample < rule_q.threshold;
				default:    match = 1'b0;
			endcase
		end
	end

	// Apply this rule to the passing token
	always_comb begin
		bit_sel = RELAY_W'(1) << rule_q.relay;
		tok_nxt = tok_in;
		if (tok_in.valid && active && rule_q.enable && match) begin
			tok_nxt.cmds    = rule_q.action ? (tok_in.cmds | bit_sel)
				: (tok_in.cmds & ~bit_sel);
			tok_nxt.applied = tok_in.applied | bit_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire
